// File: rtl/ssrp_pkg.sv
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared types and constants for the serial register poller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssrp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_REGISTER_ADDRESS  = 3'd0;
    localparam logic [2:0] CFG_HALF_PERIOD_TICKS = 3'd1;
    localparam logic [2:0] CFG_HOLD_TICKS        = 3'd2;
    localparam logic [2:0] CFG_RESYNC_TICKS      = 3'd3;
    localparam logic [2:0] CFG_POLL_ENABLE       = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int TICK_W      = 11;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_REGISTER_ADDRESS  = 8'h03;
    localparam logic [7:0]  RST_HALF_PERIOD_TICKS = 8'd22;
    localparam logic [9:0]  RST_HOLD_TICKS        = 10'd120;
    localparam logic [10:0] RST_RESYNC_TICKS      = 11'd1500;

    // ticks of the startup clock high phase
    localparam logic [TICK_W-1:0] STARTUP_HIGH_TICKS = 11'd5;

    typedef struct packed {
        logic [7:0]  register_address;
        logic [7:0]  half_period_ticks;
        logic [9:0]  hold_ticks;
        logic [10:0] resync_ticks;
        logic        poll_enable;
    } cfg_t;

    // one result beat, byte_read in the top bits
    typedef struct packed {
        logic [7:0] byte_read;
        logic       byte_valid;
        logic       data_drive;
        logic       data_level;
        logic       clock_level;
    } result_t;

endpackage

// File: rtl/ssrp_core.sv
// ----------------------------------------------------------------------------
// ssrp_core
// Bus sequencer: advances one tick per accepted beat and forms its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrp_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              sdio_sample,
    input  ssrp_pkg::cfg_t    cfg,
    output ssrp_pkg::result_t result
);

    typedef enum logic [3:0] {
        PH_S_HIGH  = 4'd0,
        PH_S_LOW   = 4'd1,
        PH_RESYNC  = 4'd2,
        PH_IDLE    = 4'd3,
        PH_W_LOW   = 4'd4,
        PH_W_HIGH  = 4'd5,
        PH_TURN    = 4'd6,
        PH_R_LOW   = 4'd7,
        PH_R_EDGE  = 4'd8,
        PH_R_HIGH  = 4'd9,
        PH_REL_LOW = 4'd10,
        PH_GAP     = 4'd11
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [2:0]                    bit_left_reg, bit_left_next;
    logic [ssrp_pkg::TICK_W-1:0]   tick_left_reg, tick_left_next;
    logic [7:0]                    shift_byte_reg, shift_byte_next;
    logic [7:0]                    last_byte_reg, last_byte_next;

    logic                          done;
    logic                          cur_bit;
    logic [ssrp_pkg::TICK_W-1:0]   half_len;
    logic [ssrp_pkg::TICK_W-1:0]   hold_len;
    logic [ssrp_pkg::TICK_W-1:0]   resync_len;
    logic                          clk_lvl, dat_lvl, dat_drv, valid;

    // zero length counts as one tick
    function automatic logic [ssrp_pkg::TICK_W-1:0] len_of(input logic [ssrp_pkg::TICK_W-1:0] n);
        len_of = (n == '0) ? ssrp_pkg::TICK_W'(1) : n;
    endfunction

    assign done       = (tick_left_reg <= ssrp_pkg::TICK_W'(1));
    assign cur_bit    = shift_byte_reg[bit_left_reg];
    assign half_len   = len_of({3'b000, cfg.half_period_ticks});
    assign hold_len   = len_of({1'b0, cfg.hold_ticks});
    assign resync_len = len_of(cfg.resync_ticks);

    // next state and line levels for this tick
    always_comb
    begin
        phase_next      = phase_reg;
        bit_left_next   = bit_left_reg;
        tick_left_next  = done ? tick_left_reg : tick_left_reg - ssrp_pkg::TICK_W'(1);
        shift_byte_next = shift_byte_reg;
        last_byte_next  = last_byte_reg;
        clk_lvl         = 1'b1;
        dat_lvl         = 1'b1;
        dat_drv         = 1'b1;
        valid           = 1'b0;

        case (phase_reg)
            PH_S_HIGH:
            begin
                if (done)
                begin
                    phase_next     = PH_S_LOW;
                    tick_left_next = ssrp_pkg::TICK_W'(1);
                end
            end
            PH_S_LOW:
            begin
                clk_lvl = 1'b0;
                if (done)
                begin
                    phase_next     = PH_RESYNC;
                    tick_left_next = resync_len;
                end
            end
            PH_W_LOW:
            begin
                clk_lvl = 1'b0;
                dat_lvl = cur_bit;
                if (done)
                begin
                    phase_next     = PH_W_HIGH;
                    tick_left_next = half_len;
                end
            end
            PH_W_HIGH:
            begin
                dat_lvl = cur_bit;
                if (done)
                begin
                    if (bit_left_reg == 3'd0)
                    begin
                        shift_byte_next = 8'h00;
                        phase_next      = PH_TURN;
                        tick_left_next  = hold_len;
                    end
                    else
                    begin
                        bit_left_next  = bit_left_reg - 3'd1;
                        phase_next     = PH_W_LOW;
                        tick_left_next = half_len;
                    end
                end
            end
            PH_TURN:
            begin
                dat_lvl = 1'b0;
                dat_drv = 1'b0;
                if (done)
                begin
                    bit_left_next  = 3'd7;
                    phase_next     = PH_R_LOW;
                    tick_left_next = half_len;
                end
            end
            PH_R_LOW:
            begin
                clk_lvl = 1'b0;
                dat_lvl = 1'b0;
                dat_drv = 1'b0;
                if (done)
                begin
                    phase_next     = PH_R_EDGE;
                    tick_left_next = ssrp_pkg::TICK_W'(1);
                end
            end
            PH_R_EDGE, PH_R_HIGH:
            begin
                dat_lvl = 1'b0;
                dat_drv = 1'b0;
                if (phase_reg == PH_R_EDGE)
                begin
                    // sample on the rising clock edge
                    shift_byte_next = {shift_byte_reg[6:0], sdio_sample};
                end
                if ((phase_reg == PH_R_EDGE) && (cfg.half_period_ticks > 8'd1))
                begin
                    phase_next     = PH_R_HIGH;
                    tick_left_next = {3'b000, cfg.half_period_ticks} - ssrp_pkg::TICK_W'(1);
                end
                else if ((phase_reg == PH_R_EDGE) || done)
                begin
                    tick_left_next = half_len;
                    if (bit_left_reg == 3'd0)
                    begin
                        phase_next = PH_REL_LOW;
                    end
                    else
                    begin
                        bit_left_next = bit_left_reg - 3'd1;
                        phase_next    = PH_R_LOW;
                    end
                end
            end
            PH_REL_LOW:
            begin
                clk_lvl = 1'b0;
                dat_lvl = 1'b0;
                dat_drv = 1'b0;
                if (done)
                begin
                    phase_next     = PH_GAP;
                    tick_left_next = hold_len;
                end
            end
            default:
            begin
                // resync end, gap end, idle and unused codes decide whether to start a read
                if (((phase_reg != PH_RESYNC) && (phase_reg != PH_GAP)) || done)
                begin
                    if (phase_reg == PH_GAP)
                    begin
                        last_byte_next = shift_byte_reg;
                        valid          = 1'b1;
                    end
                    if (cfg.poll_enable)
                    begin
                        shift_byte_next = cfg.register_address;
                        bit_left_next   = 3'd7;
                        phase_next      = PH_W_LOW;
                        tick_left_next  = half_len;
                    end
                    else
                    begin
                        phase_next     = PH_IDLE;
                        tick_left_next = ssrp_pkg::TICK_W'(1);
                    end
                end
            end
        endcase
    end

    // result of this tick, byte shown after the update
    always_comb
    begin
        result.clock_level = clk_lvl;
        result.data_level  = dat_lvl;
        result.data_drive  = dat_drv;
        result.byte_valid  = valid;
        result.byte_read   = last_byte_next;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_S_HIGH;
            bit_left_reg   <= 3'd7;
            tick_left_reg  <= ssrp_pkg::STARTUP_HIGH_TICKS;
            shift_byte_reg <= 8'h00;
            last_byte_reg  <= 8'h00;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            bit_left_reg   <= bit_left_next;
            tick_left_reg  <= tick_left_next;
            shift_byte_reg <= shift_byte_next;
            last_byte_reg  <= last_byte_next;
        end
    end

    // tick counter never reaches zero
    a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        tick_left_reg != '0)
        else $error("tick counter reached zero");

    // state moves only on an accepted beat
    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(tick_left_reg) && $stable(last_byte_reg))
        else $error("sequencer state changed without a beat");

    // a completed read latches the shifted byte
    a_valid_latch: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.byte_valid |=> last_byte_reg == $past(shift_byte_reg))
        else $error("read byte not latched on completion");

    // released data line is reported low
    a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
        !result.data_drive |-> !result.data_level && (phase_reg != PH_W_LOW))
        else $error("released data line reported high");

endmodule

// File: rtl/ssrp_skid.sv
// ----------------------------------------------------------------------------
// ssrp_skid
// Output register with one skid entry for result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssrp_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ssrp_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ssrp_pkg::result_t out_data
);

    ssrp_pkg::result_t main_reg;
    ssrp_pkg::result_t skid_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic              push;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || out_ready)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || out_ready)
        begin
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        else if (push)
        begin
            skid_reg <= in_data;
        end
    end

endmodule

// File: rtl/sensor_serial_register_poller_unit.sv
// ----------------------------------------------------------------------------
// sensor_serial_register_poller_unit
// Tick-driven master for a two-wire half-duplex sensor register port.
// ----------------------------------------------------------------------------
// Each beat on the slave stream is one timer tick and carries the sampled
// level of the data line. For every tick one result beat leaves on the
// master stream: clock and data line levels to drive, the data drive enable,
// a one-tick byte valid flag and the last byte read.
// A beat is taken every cycle while s_tready is high; its result is formed
// combinationally by the sequencer update and registered on acceptance.
// When the receiver stalls, one more tick lands in the skid entry and then
// s_tready drops until the output register drains; no result is lost.
// After reset the bus sequencer drives the clock high for five ticks, low for
// one, waits resync_ticks, then polls the configured register without end
// while poll_enable is set. Configuration registers return to their reset
// values; cfg_ready is always high. Writes are to be taken while idle only;
// the user must keep to this, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_serial_register_poller_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    // slave stream: tdata [0] sdio_sample
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,
    // master stream: tdata [0] clock_level, [1] data_level, [2] data_drive,
    // [3] byte_valid, [11:4] byte_read
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssrp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ssrp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ssrp_pkg::cfg_t    cfg_reg;
    ssrp_pkg::result_t step_result;
    ssrp_pkg::result_t out_result;
    logic              step;

    assign cfg_ready = 1'b1;
    assign step      = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.register_address  <= ssrp_pkg::RST_REGISTER_ADDRESS;
            cfg_reg.half_period_ticks <= ssrp_pkg::RST_HALF_PERIOD_TICKS;
            cfg_reg.hold_ticks        <= ssrp_pkg::RST_HOLD_TICKS;
            cfg_reg.resync_ticks      <= ssrp_pkg::RST_RESYNC_TICKS;
            cfg_reg.poll_enable       <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ssrp_pkg::CFG_REGISTER_ADDRESS:  cfg_reg.register_address  <= cfg_data[7:0];
                ssrp_pkg::CFG_HALF_PERIOD_TICKS: cfg_reg.half_period_ticks <= cfg_data[7:0];
                ssrp_pkg::CFG_HOLD_TICKS:        cfg_reg.hold_ticks        <= cfg_data[9:0];
                ssrp_pkg::CFG_RESYNC_TICKS:      cfg_reg.resync_ticks      <= cfg_data[10:0];
                ssrp_pkg::CFG_POLL_ENABLE:       cfg_reg.poll_enable       <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // bus sequencer
    ssrp_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .sdio_sample (s_tdata[0]),
        .cfg         (cfg_reg),
        .result      (step_result)
    );

    // result beat buffer
    ssrp_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (step_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {4'b0000, out_result};

endmodule

// File: verif/poll_bus_checker.sv
// ----------------------------------------------------------------------------
// poll_bus_checker
// Watches the tick, result and configuration channels of the register poller,
// predicts the bus levels of every accepted tick and compares each result
// beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module poll_bus_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [15:0]                      m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [ssrp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssrp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               pending,
    output int                               errors
);

    // bus sequencer steps
    typedef enum logic [3:0] {
        PH_START_HIGH,
        PH_START_LOW,
        PH_RESYNC,
        PH_IDLE,
        PH_ADDR_LOW,
        PH_ADDR_HIGH,
        PH_TURN,
        PH_RD_LOW,
        PH_RD_EDGE,
        PH_RD_HIGH,
        PH_REL_LOW,
        PH_GAP
    } bus_phase_t;

    // predicted sequencer state
    bus_phase_t  bus_phase;
    logic [2:0]  bits_left;
    logic [10:0] ticks_left;
    logic [7:0]  shift_reg;
    logic [7:0]  held_byte;

    // predicted register contents
    logic [7:0]  addr_cfg;
    logic [7:0]  half_cfg;
    logic [9:0]  hold_cfg;
    logic [10:0] resync_cfg;
    logic        enable_cfg;

    ssrp_pkg::result_t line_levels_due[$];
    int                fail_count = 0;
    int                beat_count = 0;

    assign errors = fail_count;

    // a zero length counts as one tick
    function void enter_phase(bus_phase_t next_phase, logic [10:0] len);
        bus_phase  = next_phase;
        ticks_left = (len == 11'd0) ? 11'd1 : len;
    endfunction

    function void begin_read();
        shift_reg = addr_cfg;
        bits_left = 3'd7;
        enter_phase(PH_ADDR_LOW, {3'b000, half_cfg});
    endfunction

    function void poll_or_idle();
        if (enable_cfg)
            begin_read();
        else
            enter_phase(PH_IDLE, 11'd1);
    endfunction

    function void next_read_bit();
        if (bits_left == 3'd0)
        begin
            enter_phase(PH_REL_LOW, {3'b000, half_cfg});
        end
        else
        begin
            bits_left = bits_left - 3'd1;
            enter_phase(PH_RD_LOW, {3'b000, half_cfg});
        end
    endfunction

    // one timer tick of the sequencer, returns the line levels it drives
    function ssrp_pkg::result_t advance_bus_tick(logic sample);
        ssrp_pkg::result_t levels;
        logic              done;
        logic              addr_bit;
        levels             = '0;
        levels.clock_level = 1'b1;
        levels.data_level  = 1'b1;
        levels.data_drive  = 1'b1;
        done     = (ticks_left <= 11'd1);
        addr_bit = shift_reg[bits_left];
        if (!done)
            ticks_left = ticks_left - 11'd1;
        case (bus_phase)
            PH_START_HIGH:
            begin
                if (done)
                    enter_phase(PH_START_LOW, 11'd1);
            end
            PH_START_LOW:
            begin
                levels.clock_level = 1'b0;
                if (done)
                    enter_phase(PH_RESYNC, resync_cfg);
            end
            PH_RESYNC:
            begin
                if (done)
                    poll_or_idle();
            end
            PH_ADDR_LOW:
            begin
                levels.clock_level = 1'b0;
                levels.data_level  = addr_bit;
                if (done)
                    enter_phase(PH_ADDR_HIGH, {3'b000, half_cfg});
            end
            PH_ADDR_HIGH:
            begin
                levels.data_level = addr_bit;
                if (done)
                begin
                    if (bits_left == 3'd0)
                    begin
                        shift_reg = 8'h00;
                        enter_phase(PH_TURN, {1'b0, hold_cfg});
                    end
                    else
                    begin
                        bits_left = bits_left - 3'd1;
                        enter_phase(PH_ADDR_LOW, {3'b000, half_cfg});
                    end
                end
            end
            PH_TURN:
            begin
                levels.data_level = 1'b0;
                levels.data_drive = 1'b0;
                if (done)
                begin
                    bits_left = 3'd7;
                    enter_phase(PH_RD_LOW, {3'b000, half_cfg});
                end
            end
            PH_RD_LOW:
            begin
                levels.clock_level = 1'b0;
                levels.data_level  = 1'b0;
                levels.data_drive  = 1'b0;
                if (done)
                    enter_phase(PH_RD_EDGE, 11'd1);
            end
            PH_RD_EDGE:
            begin
                // rising edge: take the data line
                levels.data_level = 1'b0;
                levels.data_drive = 1'b0;
                shift_reg = {shift_reg[6:0], sample};
                if (half_cfg <= 8'd1)
                    next_read_bit();
                else
                    enter_phase(PH_RD_HIGH, {3'b000, half_cfg} - 11'd1);
            end
            PH_RD_HIGH:
            begin
                levels.data_level = 1'b0;
                levels.data_drive = 1'b0;
                if (done)
                    next_read_bit();
            end
            PH_REL_LOW:
            begin
                levels.clock_level = 1'b0;
                levels.data_level  = 1'b0;
                levels.data_drive  = 1'b0;
                if (done)
                    enter_phase(PH_GAP, {1'b0, hold_cfg});
            end
            PH_GAP:
            begin
                if (done)
                begin
                    held_byte         = shift_reg;
                    levels.byte_valid = 1'b1;
                    poll_or_idle();
                end
            end
            default:
            begin
                // idle bus, also any unused step
                poll_or_idle();
            end
        endcase
        levels.byte_read = held_byte;
        return levels;
    endfunction

    task report(input string what, input int got_val, input int want_val);
        $display("beat %0d: %s got %0h expected %0h", beat_count, what, got_val, want_val);
        fail_count = fail_count + 1;
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin : watch
        ssrp_pkg::result_t got_beat;
        ssrp_pkg::result_t want_beat;
        if (!rst_n)
        begin
            bus_phase  = PH_START_HIGH;
            bits_left  = 3'd7;
            ticks_left = ssrp_pkg::STARTUP_HIGH_TICKS;
            shift_reg  = 8'h00;
            held_byte  = 8'h00;
            addr_cfg   = ssrp_pkg::RST_REGISTER_ADDRESS;
            half_cfg   = ssrp_pkg::RST_HALF_PERIOD_TICKS;
            hold_cfg   = ssrp_pkg::RST_HOLD_TICKS;
            resync_cfg = ssrp_pkg::RST_RESYNC_TICKS;
            enable_cfg = 1'b1;
            line_levels_due.delete();
            pending <= 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                beat_count = beat_count + 1;
                got_beat   = m_tdata[11:0];
                if (line_levels_due.size() == 0)
                begin
                    report("result beat with no tick waiting", int'(m_tdata), 0);
                end
                else
                begin
                    want_beat = line_levels_due.pop_front();
                    if (got_beat.clock_level != want_beat.clock_level)
                        report("clock_level", int'(got_beat.clock_level),
                               int'(want_beat.clock_level));
                    if (got_beat.data_level != want_beat.data_level)
                        report("data_level", int'(got_beat.data_level),
                               int'(want_beat.data_level));
                    if (got_beat.data_drive != want_beat.data_drive)
                        report("data_drive", int'(got_beat.data_drive),
                               int'(want_beat.data_drive));
                    if (got_beat.byte_valid != want_beat.byte_valid)
                        report("byte_valid", int'(got_beat.byte_valid),
                               int'(want_beat.byte_valid));
                    if (got_beat.byte_read != want_beat.byte_read)
                        report("byte_read", int'(got_beat.byte_read),
                               int'(want_beat.byte_read));
                end
                if (m_tdata[15:12] != 4'h0)
                    report("tdata fill bits", int'(m_tdata[15:12]), 0);
            end

            // tick beat, seen with the registers as they were before this edge
            if (s_tvalid && s_tready)
                line_levels_due.push_back(advance_bus_tick(s_tdata[0]));

            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ssrp_pkg::CFG_REGISTER_ADDRESS:  addr_cfg   = cfg_data[7:0];
                    ssrp_pkg::CFG_HALF_PERIOD_TICKS: half_cfg   = cfg_data[7:0];
                    ssrp_pkg::CFG_HOLD_TICKS:        hold_cfg   = cfg_data[9:0];
                    ssrp_pkg::CFG_RESYNC_TICKS:      resync_cfg = cfg_data[10:0];
                    ssrp_pkg::CFG_POLL_ENABLE:       enable_cfg = cfg_data[0];
                    default: ;
                endcase
            end

            pending <= line_levels_due.size();
        end
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the serial register poller: timer ticks with sampled data
// levels, register writes between phases, random idling on both streams.
// Results are checked beat by beat by the bus checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int RANDOM_PHASES   = 16;

    typedef enum {SAMPLE_RANDOM, SAMPLE_ONES, SAMPLE_ZEROS, SAMPLE_TOGGLE} sample_mode_t;
    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = 8'h00;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [15:0]                      m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ssrp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ssrp_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int pending;
    int errors;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int hold_off_req = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int idle_cycles  = 0;

    sensor_serial_register_poller_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    poll_bus_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // 12 ns clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // result receiver: random stalls, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_off_req)
        begin
            hold_seen = hold_off_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;  stall_pct <= 0;  end
            IDLE_SENDER:   begin gap_pct = 73; stall_pct <= 0;  end
            IDLE_RECEIVER: begin gap_pct = 0;  stall_pct <= 73; end
            default:       begin gap_pct = 27; stall_pct <= 27; end
        endcase
    endtask

    // send ticks, leaving tvalid high after the last beat
    task automatic send_ticks(input int count, input sample_mode_t mode);
        logic sample;
        int   i;
        cfg_valid <= 1'b0;
        for (i = 0; i < count; i++)
        begin
            case (mode)
                SAMPLE_ONES:   sample = 1'b1;
                SAMPLE_ZEROS:  sample = 1'b0;
                SAMPLE_TOGGLE: sample = i[0];
                default:       sample = 1'($urandom_range(0, 1));
            endcase
            while ($urandom_range(0, 99) < gap_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {7'b0000000, sample};
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
    endtask

    // stop offering and wait for every predicted result
    task wait_drained();
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // register write with junk in the bits above the register width
    task automatic write_reg(input logic [ssrp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ssrp_pkg::CFG_DATA_W-1:0]  val);
        logic [ssrp_pkg::CFG_DATA_W-1:0] junk;
        junk = ssrp_pkg::CFG_DATA_W'($urandom);
        case (idx)
            ssrp_pkg::CFG_REGISTER_ADDRESS,
            ssrp_pkg::CFG_HALF_PERIOD_TICKS: junk = junk & 11'h700;
            ssrp_pkg::CFG_HOLD_TICKS:        junk = junk & 11'h400;
            ssrp_pkg::CFG_POLL_ENABLE:       junk = junk & 11'h7FE;
            default:                         junk = '0;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val | junk;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int phase_no;
        int tick_count;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero lengths, startup pulse and the first address bits
        set_idle(IDLE_NONE);
        write_reg(ssrp_pkg::CFG_RESYNC_TICKS, '0);
        write_reg(ssrp_pkg::CFG_HALF_PERIOD_TICKS, '0);
        write_reg(ssrp_pkg::CFG_HOLD_TICKS, '0);
        write_reg(ssrp_pkg::CFG_REGISTER_ADDRESS, ssrp_pkg::CFG_DATA_W'(8'hA5));
        send_ticks(12, SAMPLE_TOGGLE);

        // disable in the middle of a read, which carries on, then enable again
        wait_drained();
        write_reg(ssrp_pkg::CFG_POLL_ENABLE, '0);
        send_ticks(12, SAMPLE_ONES);
        wait_drained();
        write_reg(ssrp_pkg::CFG_POLL_ENABLE, ssrp_pkg::CFG_DATA_W'(1));

        // random phases with register changes at arbitrary bus points
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++)
        begin
            wait_drained();
            set_idle(idle_mode_t'(phase_no % 4));
            tick_count = $urandom_range(20, 40);
            if ($urandom_range(0, 1))
            begin
                if ($urandom_range(0, 3) == 0)
                    write_reg(ssrp_pkg::CFG_REGISTER_ADDRESS,
                              ssrp_pkg::CFG_DATA_W'($urandom_range(0, 1) ? 8'hFF : 8'h00));
                else
                    write_reg(ssrp_pkg::CFG_REGISTER_ADDRESS,
                              ssrp_pkg::CFG_DATA_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1))
                write_reg(ssrp_pkg::CFG_HALF_PERIOD_TICKS,
                          ssrp_pkg::CFG_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 1))
                write_reg(ssrp_pkg::CFG_HOLD_TICKS,
                          ssrp_pkg::CFG_DATA_W'($urandom_range(0, 6)));
            if ($urandom_range(0, 1))
                write_reg(ssrp_pkg::CFG_RESYNC_TICKS,
                          ssrp_pkg::CFG_DATA_W'($urandom_range(0, 2047)));
            if ($urandom_range(0, 1))
                write_reg(ssrp_pkg::CFG_POLL_ENABLE,
                          ssrp_pkg::CFG_DATA_W'($urandom_range(0, 5) != 0));

            // longest settings, then shorter ones, with the longest hold in the last phase
            if (phase_no == 2)
                write_reg(ssrp_pkg::CFG_RESYNC_TICKS, ssrp_pkg::CFG_DATA_W'(11'd2047));
            if (phase_no == 4)
            begin
                write_reg(ssrp_pkg::CFG_POLL_ENABLE, ssrp_pkg::CFG_DATA_W'(1));
                write_reg(ssrp_pkg::CFG_HALF_PERIOD_TICKS, ssrp_pkg::CFG_DATA_W'(8'd255));
                write_reg(ssrp_pkg::CFG_HOLD_TICKS, ssrp_pkg::CFG_DATA_W'(1));
                tick_count = 200;
            end
            if (phase_no == 5)
                write_reg(ssrp_pkg::CFG_HALF_PERIOD_TICKS,
                          ssrp_pkg::CFG_DATA_W'($urandom_range(1, 2)));
            if (phase_no == 10)
                write_reg(ssrp_pkg::CFG_HOLD_TICKS,
                          ssrp_pkg::CFG_DATA_W'($urandom_range(1, 4)));
            if (phase_no == RANDOM_PHASES - 1)
            begin
                write_reg(ssrp_pkg::CFG_POLL_ENABLE, ssrp_pkg::CFG_DATA_W'(1));
                write_reg(ssrp_pkg::CFG_HALF_PERIOD_TICKS, ssrp_pkg::CFG_DATA_W'(1));
                write_reg(ssrp_pkg::CFG_HOLD_TICKS, ssrp_pkg::CFG_DATA_W'(10'd1023));
                tick_count = 300;
            end

            // receiver holds off while ticks keep coming
            if (phase_no == 8)
            begin
                hold_off_req <= hold_off_req + 1;
                tick_count = 100;
            end

            if (phase_no == 12)
            begin
                // sender pauses until every result is back
                send_ticks(tick_count / 2, SAMPLE_RANDOM);
                wait_drained();
                send_ticks(tick_count - tick_count / 2, SAMPLE_RANDOM);
            end
            else
            begin
                send_ticks(tick_count, SAMPLE_RANDOM);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ssrp_pkg.sv
rtl/ssrp_core.sv
rtl/ssrp_skid.sv
rtl/sensor_serial_register_poller_unit.sv
verif/poll_bus_checker.sv
verif/tb.sv
